>>> hw/rtl/bpc_pkg.sv
package bpc_pkg;

   // Default width of the millisecond time base
   localparam int TIMER_BITS_DEF = 32;

   // Timing windows fit in 15 bits (longest is 300 + 255 * 100 ms)
   localparam int WIN_W   = 15;
   localparam int UNITS_W = 8;

   localparam logic [WIN_W-1:0] DEBOUNCE_MS        = 15'd10;
   localparam logic [WIN_W-1:0] REPEAT_MS          = 15'd300;
   localparam logic [WIN_W-1:0] LONG_BASE_MS       = 15'd300;
   localparam logic [WIN_W-1:0] UNIT_MS            = 15'd100;
   localparam logic [WIN_W-1:0] CFG_WINDOW_MS      = 15'd5000;
   localparam logic [WIN_W-1:0] REMOTE_DBL_LONG_MS = 15'd1000;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_MODE       = 2'd0,
      CSR_DBL_UNITS  = 2'd1,
      CSR_LONG_UNITS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      EV_SHORT            = 3'd0,
      EV_DBL_SHORT        = 3'd1,
      EV_LONG             = 3'd2,
      EV_REPEAT_LONG      = 3'd3,
      EV_END_LONG         = 3'd4,
      EV_DBL_LONG         = 3'd5,
      EV_DBL_LONG_TIMEOUT = 3'd6,
      EV_WAKE             = 3'd7
   } ev_type;

   typedef enum logic [2:0] {
      CMD_NONE           = 3'd0,
      CMD_REMOTE_SHORT   = 3'd1,
      CMD_REMOTE_LONG    = 3'd2,
      CMD_REMOTE_RELEASE = 3'd3,
      CMD_PAIRING        = 3'd4,
      CMD_LED_BLINK      = 3'd5,
      CMD_LED_OFF        = 3'd6,
      CMD_RESET          = 3'd7
   } cmd_type;

   typedef struct packed {
      logic               mode;
      logic [UNITS_W-1:0] dbl_units;
      logic [UNITS_W-1:0] long_units;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      ev_type  code;
      cmd_type cmd;
   } result_type;

   // Translate an event into the command for the current mode
   function automatic cmd_type map_command(input logic mode, input ev_type ev);
      cmd_type c;
      c = CMD_NONE;
      if (mode) begin
         unique case (ev)
            EV_SHORT:            c = CMD_PAIRING;
            EV_LONG:             c = CMD_LED_BLINK;
            EV_DBL_LONG_TIMEOUT: c = CMD_LED_OFF;
            EV_DBL_LONG:         c = CMD_RESET;
            default:             c = CMD_NONE;
         endcase
      end else begin
         unique case (ev) inside
            EV_SHORT, EV_DBL_SHORT:      c = CMD_REMOTE_SHORT;
            EV_LONG, EV_REPEAT_LONG:     c = CMD_REMOTE_LONG;
            EV_END_LONG:                 c = CMD_REMOTE_RELEASE;
            default:                     c = CMD_NONE;
         endcase
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/bpc_core.sv
module bpc_core #(
   parameter int TIMER_BITS = bpc_pkg::TIMER_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 pin_level,
   input  bpc_pkg::cfg_type     cfg,
   output bpc_pkg::result_type  result
);
   import bpc_pkg::*;

   // Times are kept relative to the running tick count:
   //   dl_ff  = now - check deadline, deadline reached while its MSB is clear
   //   age_ff = now - time of last accepted edge
   logic [TIMER_BITS-1:0] dl_ff, dl_in;
   logic [TIMER_BITS-1:0] age_ff, age_in;
   logic armed_ff, armed_in;
   logic level_ff, level_in;
   logic last_ff, last_in;
   logic ldp_ff, ldp_in;
   logic sdp_ff, sdp_in;
   logic lra_ff, lra_in;

   logic [WIN_W-1:0] t_short, t_long, t_dlong, dl_dt;
   logic             dl_set, edge_set, fire;
   ev_type           ev;

   // True when edge time plus w has been reached
   function automatic logic reached(input logic [TIMER_BITS-1:0] age,
                                    input logic [WIN_W-1:0] w);
      logic [TIMER_BITS-1:0] d;
      d = age - TIMER_BITS'(w);
      return !d[TIMER_BITS-1];
   endfunction

   // Timing windows from the configuration
   assign t_short = cfg.mode ? '0 : WIN_W'(cfg.dbl_units) * UNIT_MS;
   assign t_long  = cfg.mode ? CFG_WINDOW_MS
                             : LONG_BASE_MS + WIN_W'(cfg.long_units) * UNIT_MS;
   assign t_dlong = cfg.mode ? CFG_WINDOW_MS : REMOTE_DBL_LONG_MS;

   // Classify one tick
   always_comb begin
      level_in = level_ff;
      last_in  = last_ff;
      armed_in = armed_ff;
      ldp_in   = ldp_ff;
      sdp_in   = sdp_ff;
      lra_in   = lra_ff;
      dl_set   = 1'b0;
      dl_dt    = DEBOUNCE_MS;
      edge_set = 1'b0;
      fire     = 1'b0;
      ev       = EV_SHORT;

      if (pin_level != level_ff) begin
         // New level: restart debounce; the fresh deadline cannot be due yet
         level_in = pin_level;
         armed_in = 1'b1;
         dl_set   = 1'b1;
         dl_dt    = DEBOUNCE_MS;
      end else if (armed_ff && !dl_ff[TIMER_BITS-1]) begin
         case ({level_ff, last_ff})
            2'b11: begin
               // Released and idle: expire pending windows
               if (ldp_ff && reached(age_ff, t_dlong)) begin
                  ldp_in = 1'b0;
                  fire   = 1'b1;
                  ev     = EV_DBL_LONG_TIMEOUT;
               end
               if (sdp_ff && reached(age_ff, t_short)) begin
                  sdp_in = 1'b0;
               end
               if (!ldp_in && !sdp_in) begin
                  armed_in = 1'b0;
               end
               if (sdp_in) begin
                  dl_set = 1'b1;
                  dl_dt  = t_short;
               end else if (ldp_in) begin
                  dl_set = 1'b1;
                  dl_dt  = t_dlong;
               end
            end
            2'b10: begin
               // Release
               if (lra_ff) begin
                  lra_in = 1'b0;
                  fire   = 1'b1;
                  ev     = EV_END_LONG;
               end else if (sdp_ff) begin
                  sdp_in = 1'b0;
                  fire   = 1'b1;
                  ev     = EV_DBL_SHORT;
               end else if (!reached(age_ff, t_long)) begin
                  sdp_in = 1'b1;
                  if (t_short == '0) begin
                     fire = 1'b1;
                     ev   = EV_SHORT;
                  end
               end
               if (ldp_ff) begin
                  dl_set = 1'b1;
                  dl_dt  = t_dlong;
               end else if (sdp_in && (t_short != '0)) begin
                  dl_set = 1'b1;
                  dl_dt  = t_short;
               end
               edge_set = 1'b1;
               last_in  = level_ff;
               armed_in = 1'b1;
            end
            2'b01: begin
               // Press: wake and start the long timer
               edge_set = 1'b1;
               dl_set   = 1'b1;
               dl_dt    = t_long;
               last_in  = level_ff;
               armed_in = 1'b1;
               fire     = 1'b1;
               ev       = EV_WAKE;
            end
            default: begin
               // Held
               fire = 1'b1;
               if (lra_ff) begin
                  ldp_in = 1'b0;
                  dl_set = 1'b1;
                  dl_dt  = REPEAT_MS;
                  ev     = EV_REPEAT_LONG;
               end else if (ldp_ff) begin
                  lra_in   = 1'b0;
                  ldp_in   = 1'b0;
                  armed_in = 1'b0;
                  ev       = EV_DBL_LONG;
               end else begin
                  ldp_in = 1'b1;
                  lra_in = 1'b1;
                  dl_set = 1'b1;
                  dl_dt  = t_long;
                  ev     = EV_LONG;
               end
            end
         endcase
      end
   end

   // Advance relative times by one tick
   assign dl_in  = dl_set ? (TIMER_BITS'(1) - TIMER_BITS'(dl_dt)) : (dl_ff + TIMER_BITS'(1));
   assign age_in = edge_set ? TIMER_BITS'(1) : (age_ff + TIMER_BITS'(1));

   // Result word for this tick
   always_comb begin
      result.valid = fire;
      result.code  = fire ? ev : EV_SHORT;
      result.cmd   = (fire && (ev != EV_WAKE)) ? map_command(cfg.mode, ev) : CMD_NONE;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff    <= '0;
         age_ff   <= '0;
         armed_ff <= 1'b0;
         level_ff <= 1'b1;
         last_ff  <= 1'b1;
         ldp_ff   <= 1'b0;
         sdp_ff   <= 1'b0;
         lra_ff   <= 1'b0;
      end else if (accept) begin
         dl_ff    <= dl_in;
         age_ff   <= age_in;
         armed_ff <= armed_in;
         level_ff <= level_in;
         last_ff  <= last_in;
         ldp_ff   <= ldp_in;
         sdp_ff   <= sdp_in;
         lra_ff   <= lra_in;
      end
   end

endmodule

>>> hw/rtl/bpc_out.sv
module bpc_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  bpc_pkg::result_type  result_in,
   input  logic                 out_ready,
   output logic                 in_ready,
   output logic                 out_valid,
   output bpc_pkg::result_type  result
);
   import bpc_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Take a new word whenever the register is empty or drains this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign result    = data_ff;

endmodule

>>> hw/rtl/button_press_classifier_top.sv
// Button press classifier. Each input word is one millisecond tick carrying the raw
// active-low button level; each accepted word produces exactly one result word that
// reports whether an event (wake, short, double short, long, repeated long, end of
// long, double long, double-long timeout) fired on that tick, and the command it maps
// to. A result is valid in the cycle after accept; a word is taken each clock unless
// rsp_tready is low and the result register, the only storage between sides, is full;
// it refills in the same cycle it drains. Windows follow configuration registers at
// once; users must write them via the csr port with no tick in flight (not enforced).
module button_press_classifier_top #(
   parameter int TIMER_BITS = bpc_pkg::TIMER_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] pin_level, [7:1] zero
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] event_valid, [3:1] event_code, [6:4] command,
                                   // [7] zero
   input  logic       csr_we,
   input  logic [1:0] csr_addr,
   input  logic [7:0] csr_wdata
);
   import bpc_pkg::*;

   cfg_type    cfg_ff;
   logic       accept;
   result_type step_result;
   result_type out_result;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_MODE:       cfg_ff.mode       <= csr_wdata[0];
            CSR_DBL_UNITS:  cfg_ff.dbl_units  <= csr_wdata[UNITS_W-1:0];
            CSR_LONG_UNITS: cfg_ff.long_units <= csr_wdata[UNITS_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_tvalid && req_tready;

   bpc_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pin_level (req_tdata[0]),
      .cfg       (cfg_ff),
      .result    (step_result)
   );

   bpc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .result_in (step_result),
      .out_ready (rsp_tready),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .result    (out_result)
   );

   assign rsp_tdata = {1'b0, out_result.cmd, out_result.code, out_result.valid};

   // Every accepted tick leaves a result word in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted tick produced no result word");

   // A tick without an event carries zero code and command
   a_no_event_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[6:1] == 6'd0)
      else $error("idle result word carries a code or command");

   // Wake never issues a command
   a_wake_no_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] && (rsp_tdata[3:1] == EV_WAKE) |->
      rsp_tdata[6:4] == CMD_NONE)
      else $error("wake event issued a command");

endmodule
